// ----- rtl/bol_pkg.sv -----
package bol_pkg;

    localparam int MAX_INPUTS  = 4;
    localparam int MAX_RANK    = 8;
    localparam int INDEX_WIDTH = 32;
    localparam int DIM_WIDTH   = 16;
    localparam int CNT_WIDTH   = $clog2(MAX_RANK + 1);
    localparam int LANE_WIDTH  = $clog2(MAX_INPUTS);
    localparam int PROD_WIDTH  = INDEX_WIDTH + DIM_WIDTH;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_ADD    = 2'd1,
        OP_LOCATE = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_RANK     = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD0,
        S_ADD1,
        S_ADD_LANE,
        S_LOC_HEAD,
        S_LOC_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]             op;
        logic [DIM_WIDTH-1:0]   dim_a;
        logic [DIM_WIDTH-1:0]   dim_b;
        logic [DIM_WIDTH-1:0]   dim_c;
        logic [DIM_WIDTH-1:0]   dim_d;
        logic [INDEX_WIDTH-1:0] out_index;
    } t_in_item;

    typedef struct packed {
        logic [1:0]             status;
        logic [INDEX_WIDTH-1:0] offset_a;
        logic [INDEX_WIDTH-1:0] offset_b;
        logic [INDEX_WIDTH-1:0] offset_c;
        logic [INDEX_WIDTH-1:0] offset_d;
        logic [INDEX_WIDTH-1:0] element_total;
    } t_out_item;

    typedef struct packed {
        logic [INDEX_WIDTH-1:0]                 ostride;
        logic [MAX_INPUTS-1:0][INDEX_WIDTH-1:0] stride;
    } t_group;

    typedef struct packed {
        logic push;
        logic rot;
    } t_cell_ctl;

    function automatic logic [LANE_WIDTH:0] lanes_used(input logic [2:0] cnt);
        if (cnt == 3'd0) begin
            lanes_used = (LANE_WIDTH + 1)'(1);
        end else if ({29'd0, cnt} > MAX_INPUTS) begin
            lanes_used = (LANE_WIDTH + 1)'(MAX_INPUTS);
        end else begin
            lanes_used = (LANE_WIDTH + 1)'(cnt);
        end
    endfunction

endpackage

// ----- rtl/bol_cell.sv -----
module bol_cell (
    input  logic               i_clk,
    input  bol_pkg::t_cell_ctl i_ctl,
    input  bol_pkg::t_group    i_up,
    input  bol_pkg::t_group    i_dn,
    output bol_pkg::t_group    o_grp
);
    import bol_pkg::*;

    t_group r_grp;

    // push moves groups outward, rot brings the next outer group to the head
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_grp <= i_up;
        end else if (i_ctl.rot) begin
            r_grp <= i_dn;
        end
    end

    assign o_grp = r_grp;

endmodule

// ----- rtl/bol_divider.sv -----
module bol_divider (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_start,
    input  logic [bol_pkg::INDEX_WIDTH-1:0]              i_dividend,
    input  logic [bol_pkg::INDEX_WIDTH-1:0]              i_divisor,
    input  logic [bol_pkg::MAX_INPUTS-1:0][bol_pkg::INDEX_WIDTH-1:0] i_stride,
    output logic                                         o_done,
    output logic [bol_pkg::INDEX_WIDTH-1:0]              o_rem,
    output logic [bol_pkg::MAX_INPUTS-1:0][bol_pkg::INDEX_WIDTH-1:0] o_prod
);
    import bol_pkg::*;

    localparam int BW = $clog2(INDEX_WIDTH);

    logic                                   r_busy;
    logic                                   r_done;
    logic [BW-1:0]                          r_cnt;
    logic [INDEX_WIDTH-1:0]                 r_part;
    logic [INDEX_WIDTH-1:0]                 r_dvd;
    logic [MAX_INPUTS-1:0][INDEX_WIDTH-1:0] r_acc;
    logic [INDEX_WIDTH:0]                   trial;
    logic [INDEX_WIDTH:0]                   dsr;
    logic [INDEX_WIDTH:0]                   diff;
    logic                                   ge;

    // restoring step, quotient bit also drives shift-add of each stride
    assign trial = {r_part, r_dvd[INDEX_WIDTH-1]};
    assign dsr   = {1'b0, i_divisor};
    assign diff  = trial - dsr;
    assign ge    = trial >= dsr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == BW'(INDEX_WIDTH - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_part <= '0;
            r_dvd  <= i_dividend;
            r_acc  <= '0;
        end else if (r_busy) begin
            r_part <= ge ? diff[INDEX_WIDTH-1:0] : trial[INDEX_WIDTH-1:0];
            r_dvd  <= {r_dvd[INDEX_WIDTH-2:0], 1'b0};
            for (int j = 0; j < MAX_INPUTS; j++) begin
                r_acc[j] <= {r_acc[j][INDEX_WIDTH-2:0], 1'b0}
                          + (ge ? i_stride[j] : '0);
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_part;
    assign o_prod = r_acc;

endmodule

// ----- rtl/broadcast_offset_locator.sv -----
// channel | direction | handshake                  | payload
// input   | in        | i_in_valid / o_in_stall    | i_in_item  (t_in_item)
// output  | out       | o_out_valid / i_out_stall  | o_out_item (t_out_item)
// config  | in        | i_cfg_we                   | i_cfg_data (input_count)
//
// clear and unknown ops go straight to the done state; add computes the size with
// a 32x16 multiplier, then, unless it overflows, updates the running strides lane by lane
// locate walks the group chain from the head cell:
// the restoring divider takes one quotient bit per cycle for each group
// and the group chain rotates once per cell back to its starting order
// reset is synchronous active low and clears counts, pattern and products
// a finished item waits in the output register while a new item is taken
module broadcast_offset_locator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  bol_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output bol_pkg::t_out_item o_out_item,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_data
);
    import bol_pkg::*;

    t_state r_state, n_state;

    logic [2:0]                             r_cfg;
    t_in_item                               r_item;
    logic [CNT_WIDTH-1:0]                   r_gc;
    logic [CNT_WIDTH-1:0]                   r_axis;
    logic [CNT_WIDTH-1:0]                   r_step;
    logic [LANE_WIDTH-1:0]                  r_lane;
    logic [MAX_INPUTS-1:0][INDEX_WIDTH-1:0] r_rmul;
    logic [MAX_INPUTS-1:0]                  r_pat;
    logic [MAX_INPUTS-1:0]                  r_next;
    logic [INDEX_WIDTH-1:0]                 r_oprod;
    logic [DIM_WIDTH-1:0]                   r_shape;
    logic [PROD_WIDTH-1:0]                  r_mul;
    logic [INDEX_WIDTH-1:0]                 r_rem;
    logic [MAX_INPUTS-1:0][INDEX_WIDTH-1:0] r_offs;
    logic [1:0]                             r_status;
    logic                                   r_out_valid;
    t_out_item                              r_out;

    logic                                   accept;
    logic                                   out_free;
    logic [LANE_WIDTH:0]                    n_used;
    logic [MAX_INPUTS-1:0][DIM_WIDTH-1:0]   dims;
    logic [MAX_INPUTS-1:0]                  nxt;
    logic [DIM_WIDTH-1:0]                   shape;
    logic                                   bad;
    logic                                   grow;
    t_cell_ctl                              cell_ctl;
    logic                                   dv_start;
    logic                                   dv_done;
    logic [INDEX_WIDTH-1:0]                 dv_rem;
    logic [MAX_INPUTS-1:0][INDEX_WIDTH-1:0] dv_prod;
    logic [INDEX_WIDTH-1:0]                 divisor;
    t_group                                 new_grp;
    t_group                                 grp [MAX_RANK];

    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign n_used   = lanes_used(r_cfg);

    assign dims[0] = r_item.dim_a;
    assign dims[1] = r_item.dim_b;
    assign dims[2] = r_item.dim_c;
    assign dims[3] = r_item.dim_d;

    // first non-one dimension sets the shape, any other differing one or a zero is bad
    always_comb begin
        shape = DIM_WIDTH'(1);
        bad   = 1'b0;
        nxt   = '0;
        for (int j = MAX_INPUTS - 1; j >= 0; j--) begin
            if ((LANE_WIDTH + 1)'(j) < n_used && dims[j] != DIM_WIDTH'(1)) begin
                shape = dims[j];
            end
        end
        for (int j = 0; j < MAX_INPUTS; j++) begin
            if ((LANE_WIDTH + 1)'(j) < n_used) begin
                if (dims[j] == '0) begin
                    bad = 1'b1;
                end else if (dims[j] != DIM_WIDTH'(1)) begin
                    nxt[j] = 1'b1;
                    if (dims[j] != shape) begin
                        bad = 1'b1;
                    end
                end
            end
        end
    end

    // a new group starts when the broadcast pattern changes and fewer than MAX_RANK groups exist
    assign grow = (r_next != r_pat) && (r_gc < CNT_WIDTH'(MAX_RANK));

    always_comb begin
        new_grp.ostride = r_oprod;
        for (int j = 0; j < MAX_INPUTS; j++) begin
            new_grp.stride[j] = r_next[j] ? r_rmul[j] : '0;
        end
    end

    // the head cell always holds the outermost group still to be walked
    generate
        for (genvar k = 0; k < MAX_RANK; k++) begin : g_cell
            bol_cell u_cell (
                .i_clk (i_clk),
                .i_ctl (cell_ctl),
                .i_up  (k == 0 ? new_grp : grp[(k + MAX_RANK - 1) % MAX_RANK]),
                .i_dn  (grp[(k + 1) % MAX_RANK]),
                .o_grp (grp[k])
            );
        end
    endgenerate

    assign divisor = (grp[0].ostride == '0) ? INDEX_WIDTH'(1) : grp[0].ostride;

    bol_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (dv_start),
        .i_dividend (r_rem),
        .i_divisor  (divisor),
        .i_stride   (grp[0].stride),
        .o_done     (dv_done),
        .o_rem      (dv_rem),
        .o_prod     (dv_prod)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_in_item.op)
                        OP_ADD:    n_state = S_ADD0;
                        OP_LOCATE: n_state = S_LOC_HEAD;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_ADD0: begin
                if (r_axis >= CNT_WIDTH'(MAX_RANK) || bad || shape == DIM_WIDTH'(1)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_ADD1;
                end
            end
            S_ADD1: begin
                if (r_mul[PROD_WIDTH-1:INDEX_WIDTH] != '0) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_ADD_LANE;
                end
            end
            S_ADD_LANE: begin
                if (r_lane == LANE_WIDTH'(MAX_INPUTS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_LOC_HEAD: begin
                if (r_step == CNT_WIDTH'(MAX_RANK)) begin
                    n_state = S_DONE;
                end else if (r_step < r_gc) begin
                    n_state = S_LOC_DIV;
                end
            end
            S_LOC_DIV: begin
                if (dv_done) begin
                    n_state = S_LOC_HEAD;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_stall    = (r_state != S_IDLE);
        dv_start      = 1'b0;
        cell_ctl.push = 1'b0;
        cell_ctl.rot  = 1'b0;
        case (r_state)
            S_ADD1: begin
                cell_ctl.push = (r_mul[PROD_WIDTH-1:INDEX_WIDTH] == '0) && grow;
            end
            S_LOC_HEAD: begin
                if (r_step != CNT_WIDTH'(MAX_RANK)) begin
                    dv_start     = (r_step < r_gc);
                    cell_ctl.rot = (r_step >= r_gc);
                end
            end
            S_LOC_DIV: begin
                cell_ctl.rot = dv_done;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg       <= 3'd1;
            r_gc        <= '0;
            r_axis      <= '0;
            r_pat       <= '0;
            r_oprod     <= INDEX_WIDTH'(1);
            r_out_valid <= 1'b0;
            for (int j = 0; j < MAX_INPUTS; j++) begin
                r_rmul[j] <= INDEX_WIDTH'(1);
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            // a finished item loads the output register, else a taken one leaves it
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept && i_in_item.op == OP_CLEAR) begin
                        r_gc    <= '0;
                        r_axis  <= '0;
                        r_pat   <= '0;
                        r_oprod <= INDEX_WIDTH'(1);
                        for (int j = 0; j < MAX_INPUTS; j++) begin
                            r_rmul[j] <= INDEX_WIDTH'(1);
                        end
                    end
                end
                S_ADD0: begin
                    if (r_axis < CNT_WIDTH'(MAX_RANK) && !bad && shape == DIM_WIDTH'(1)) begin
                        r_axis <= r_axis + 1'b1;
                    end
                end
                S_ADD1: begin
                    if (r_mul[PROD_WIDTH-1:INDEX_WIDTH] == '0) begin
                        r_axis  <= r_axis + 1'b1;
                        r_oprod <= r_mul[INDEX_WIDTH-1:0];
                        if (grow) begin
                            r_gc  <= r_gc + 1'b1;
                            r_pat <= r_next;
                        end
                    end
                end
                S_ADD_LANE: begin
                    if (r_pat[r_lane]) begin
                        r_rmul[r_lane] <= r_rmul[r_lane]
                                          * {{(INDEX_WIDTH-DIM_WIDTH){1'b0}}, r_shape};
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // payload side
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_item   <= i_in_item;
                    r_status <= ST_OK;
                    r_offs   <= '0;
                    r_step   <= '0;
                    r_lane   <= '0;
                    r_rem    <= i_in_item.out_index;
                end
            end
            S_ADD0: begin
                r_shape <= shape;
                r_next  <= nxt;
                r_mul   <= {{DIM_WIDTH{1'b0}}, r_oprod} * {{INDEX_WIDTH{1'b0}}, shape};
                if (r_axis >= CNT_WIDTH'(MAX_RANK)) begin
                    r_status <= ST_RANK;
                end else if (bad) begin
                    r_status <= ST_MISMATCH;
                end
            end
            S_ADD1: begin
                if (r_mul[PROD_WIDTH-1:INDEX_WIDTH] != '0) begin
                    r_status <= ST_OVERFLOW;
                end
            end
            S_ADD_LANE: begin
                r_lane <= r_lane + 1'b1;
            end
            S_LOC_HEAD: begin
                if (r_step != CNT_WIDTH'(MAX_RANK) && r_step >= r_gc) begin
                    r_step <= r_step + 1'b1;
                end
            end
            S_LOC_DIV: begin
                if (dv_done) begin
                    r_rem  <= dv_rem;
                    r_step <= r_step + 1'b1;
                    for (int j = 0; j < MAX_INPUTS; j++) begin
                        if ((LANE_WIDTH + 1)'(j) < n_used) begin
                            r_offs[j] <= r_offs[j] + dv_prod[j];
                        end
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    r_out.status        <= r_status;
                    r_out.offset_a      <= r_offs[0];
                    r_out.offset_b      <= r_offs[1];
                    r_out.offset_c      <= r_offs[2];
                    r_out.offset_d      <= r_offs[3];
                    r_out.element_total <= r_oprod;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_gc_le_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gc <= r_axis)
        else $error("group count above axis count");

    a_axis_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_axis <= CNT_WIDTH'(MAX_RANK))
        else $error("axis count above rank limit");

    a_div_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOC_DIV && dv_done) |-> (r_step < r_gc))
        else $error("division finished for a group that does not exist");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_item.op == OP_CLEAR) |=> (r_gc == '0 && r_axis == '0))
        else $error("clear left groups behind");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dv_start |=> (r_state == S_LOC_DIV))
        else $error("divider started outside a locate walk");

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
    import bol_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 400;

    // shadow of the block: group table, running strides and sizes
    class broadcast_scoreboard;
        logic [2:0]             lane_cfg;
        logic [INDEX_WIDTH-1:0] in_stride [MAX_RANK][MAX_INPUTS];
        logic [INDEX_WIDTH-1:0] out_stride [MAX_RANK];
        int                     groups;
        int                     axes;
        logic [INDEX_WIDTH-1:0] run_mult [MAX_INPUTS];
        bit                     pattern [MAX_INPUTS];
        logic [INDEX_WIDTH-1:0] total;
        t_out_item              expected_q[$];
        int                     mismatches;

        function new();
            lane_cfg   = 3'd1;
            mismatches = 0;
            clear_shape();
        endfunction

        function void clear_shape();
            groups = 0;
            axes   = 0;
            total  = 1;
            for (int i = 0; i < MAX_INPUTS; i++) begin
                run_mult[i] = 1;
                pattern[i]  = 0;
            end
        endfunction

        function int lanes();
            if (lane_cfg == 0) return 1;
            if (lane_cfg > MAX_INPUTS) return MAX_INPUTS;
            return lane_cfg;
        endfunction

        function t_status add_axis(t_in_item it);
            logic [DIM_WIDTH-1:0] dims [MAX_INPUTS];
            logic [63:0]          shape;
            bit                   nxt [MAX_INPUTS];
            bit                   changed;
            dims[0] = it.dim_a;
            dims[1] = it.dim_b;
            dims[2] = it.dim_c;
            dims[3] = it.dim_d;
            shape   = 1;
            changed = 0;
            if (axes >= MAX_RANK) return ST_RANK;
            for (int i = 0; i < MAX_INPUTS; i++) nxt[i] = 0;
            for (int i = 0; i < lanes(); i++) begin
                if (dims[i] == 0) return ST_MISMATCH;
                if (dims[i] != 1) begin
                    nxt[i] = 1;
                    if (shape == 1) shape = 64'(dims[i]);
                    else if (shape != 64'(dims[i])) return ST_MISMATCH;
                end
            end
            if (shape == 1) begin
                axes++;
                return ST_OK;
            end
            if ({32'd0, total} * shape > 64'hFFFF_FFFF) return ST_OVERFLOW;
            axes++;
            for (int i = 0; i < MAX_INPUTS; i++)
                if (nxt[i] != pattern[i]) changed = 1;
            if (changed && groups < MAX_RANK) begin
                for (int i = 0; i < MAX_INPUTS; i++) begin
                    pattern[i]          = nxt[i];
                    in_stride[groups][i] = nxt[i] ? run_mult[i] : '0;
                end
                out_stride[groups] = total;
                groups++;
            end
            for (int i = 0; i < MAX_INPUTS; i++)
                if (pattern[i]) run_mult[i] = run_mult[i] * shape[31:0];
            total = total * shape[31:0];
            return ST_OK;
        endfunction

        // note an accepted item and queue its expected result
        function void note_item(t_in_item it);
            t_out_item              r;
            logic [INDEX_WIDTH-1:0] offs [MAX_INPUTS];
            logic [INDEX_WIDTH-1:0] rem, os, q;
            r    = '0;
            for (int i = 0; i < MAX_INPUTS; i++) offs[i] = '0;
            case (t_op'(it.op))
                OP_CLEAR: clear_shape();
                OP_ADD:   r.status = add_axis(it);
                OP_LOCATE: begin
                    rem = it.out_index;
                    for (int g = groups - 1; g >= 0; g--) begin
                        os  = (out_stride[g] == 0) ? 1 : out_stride[g];
                        q   = rem / os;
                        rem = rem % os;
                        for (int j = 0; j < lanes(); j++)
                            offs[j] = offs[j] + in_stride[g][j] * q;
                    end
                end
                default: ;
            endcase
            r.offset_a      = offs[0];
            r.offset_b      = offs[1];
            r.offset_c      = offs[2];
            r.offset_d      = offs[3];
            r.element_total = total;
            expected_q.push_back(r);
        endfunction

        function void check_result(t_out_item got);
            t_out_item e;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            e = expected_q.pop_front();
            if (got.status !== e.status || got.offset_a !== e.offset_a ||
                got.offset_b !== e.offset_b || got.offset_c !== e.offset_c ||
                got.offset_d !== e.offset_d || got.element_total !== e.element_total) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: status %0d/%0d offs %h %h %h %h / %h %h %h %h tot %h/%h",
                             e.status, got.status, e.offset_a, e.offset_b, e.offset_c,
                             e.offset_d, got.offset_a, got.offset_b, got.offset_c,
                             got.offset_d, e.element_total, got.element_total);
            end
        endfunction
    endclass

    logic       clk = 0;
    logic       rst_n = 0;
    logic       in_valid = 0;
    logic       in_stall;
    t_in_item   in_item = '0;
    logic       out_valid;
    logic       out_stall = 0;
    t_out_item  out_item;
    logic       cfg_we = 0;
    logic [2:0] cfg_data = 3'd1;

    broadcast_scoreboard sb = new();
    int  idle_cycles = 0;
    bit  hold_off = 0;
    bit  stim_done = 0;

    always #2 clk = ~clk;

    broadcast_offset_locator i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    // monitor: note every accepted item, check every accepted result
    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall) sb.note_item(in_item);
        if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
        if (rst_n && !((in_valid && !in_stall) || (out_valid && !out_stall)))
            idle_cycles <= idle_cycles + 1;
        else
            idle_cycles <= 0;
    end

    // watchdog on cycles with no item moving
    always @(posedge clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver: random stall per item, plus one long hold-off on request
    initial begin
        int n;
        @(posedge clk iff rst_n);
        forever begin
            if (hold_off) begin
                out_stall <= 1;
                repeat (300) @(posedge clk);
                hold_off = 0;
            end
            n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            if (n != 0) begin
                out_stall <= 1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 0;
            @(posedge clk iff out_valid);
        end
    end

    // valid stays up after an accept so that a following item can go back to back
    task automatic send_item(t_in_item it, bit no_gap = 0);
        int n;
        n = no_gap ? 0 : $urandom_range(0, 11);
        if (n != 0) begin
            in_valid <= 0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_op(t_op op, logic [15:0] a, logic [15:0] b, logic [15:0] c,
                           logic [15:0] d, logic [31:0] idx);
        t_in_item it;
        it.op = op; it.dim_a = a; it.dim_b = b; it.dim_c = c; it.dim_d = d;
        it.out_index = idx;
        send_item(it);
    endtask

    // wait until idle, then write the lane count
    task automatic set_lanes(logic [2:0] v);
        in_valid <= 0;
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we   <= 1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 0;
        sb.lane_cfg = v;
    endtask

    function automatic logic [15:0] pick_dim();
        case ($urandom_range(0, 9))
            0:       return 16'hFFFF;
            1:       return 16'(1 << $urandom_range(0, 15));
            2:       return 16'($urandom);
            default: return 16'($urandom_range(2, 7));
        endcase
    endfunction

    // mostly well-formed axis: one shape, random broadcast pattern; sometimes a mismatch, a zero or all ones
    function automatic t_in_item random_axis();
        t_in_item    it;
        logic [15:0] s;
        int          r;
        it = '0;
        it.op = OP_ADD;
        s  = pick_dim();
        it.dim_a = $urandom_range(0, 2) ? s : 16'd1;
        it.dim_b = $urandom_range(0, 1) ? s : 16'd1;
        it.dim_c = $urandom_range(0, 1) ? s : 16'd1;
        it.dim_d = $urandom_range(0, 1) ? s : 16'd1;
        r = $urandom_range(0, 19);
        if (r == 0) it.dim_b = pick_dim();                 // likely mismatch
        else if (r == 1) it.dim_c = 16'd0;                  // zero dimension
        else if (r == 2) it = {OP_ADD, 64'h0001_0001_0001_0001, 32'($urandom)};
        it.out_index = $urandom;
        return it;
    endfunction

    function automatic t_in_item random_locate();
        t_in_item it;
        it = '0;
        it.op = OP_LOCATE;
        it.dim_a = 16'($urandom); it.dim_b = 16'($urandom);
        it.dim_c = 16'($urandom); it.dim_d = 16'($urandom);
        case ($urandom_range(0, 5))
            0:       it.out_index = $urandom;
            1:       it.out_index = sb.total + $urandom_range(0, 100);
            2:       it.out_index = 32'hFFFF_FFFF;
            default: it.out_index = (sb.total == 0) ? $urandom : $urandom % sb.total;
        endcase
        return it;
    endfunction

    initial begin
        int         count;
        int         axes_left;
        logic [2:0] lane_list [6] = '{3'd4, 3'd0, 3'd7, 3'd2, 3'd3, 3'd4};
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, every op, special cases
        send_op(OP_LOCATE, 16'd1, 16'd1, 16'd1, 16'd1, 32'd5);       // no groups
        send_op(OP_ADD, 16'd3, 16'd5, 16'd1, 16'd1, 32'd0);          // lane b ignored
        send_op(OP_ADD, 16'd0, 16'd1, 16'd1, 16'd1, 32'd0);          // zero dim
        send_op(OP_ADD, 16'hFFFF, 16'd1, 16'd1, 16'd1, 32'd0);
        send_op(OP_ADD, 16'hFFFF, 16'd1, 16'd1, 16'd1, 32'd0);       // overflow
        send_op(OP_LOCATE, 16'd0, 16'd0, 16'd0, 16'd0, 32'hFFFF_FFFF);
        send_op(OP_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_op(OP_CLEAR, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0);
        set_lanes(3'd4);
        send_op(OP_ADD, 16'd2, 16'd2, 16'd1, 16'd2, 32'd0);
        send_op(OP_ADD, 16'd1, 16'd1, 16'd1, 16'd1, 32'd0);          // all-one skip
        send_op(OP_ADD, 16'd3, 16'd3, 16'd1, 16'd3, 32'd0);          // merges
        send_op(OP_ADD, 16'd4, 16'd1, 16'd4, 16'd1, 32'd0);
        send_op(OP_ADD, 16'd4, 16'd5, 16'd1, 16'd1, 32'd0);          // mismatch
        for (int i = 0; i < 6; i++)
            send_op(OP_ADD, 16'd1, 16'd1, 16'd1, 16'd1, 32'd0);      // last two hit rank limit
        send_op(OP_LOCATE, 16'd0, 16'd0, 16'd0, 16'd0, 32'd71);
        send_op(OP_LOCATE, 16'd0, 16'd0, 16'd0, 16'd0, 32'd1000);    // beyond size
        send_op(OP_CLEAR, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0);

        // random: shapes built axis by axis, then a burst of locates
        count = 0;
        for (int phase = 0; phase < 6; phase++) begin
            set_lanes(lane_list[phase]);
            for (int s = 0; s < 10; s++) begin
                send_op(OP_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), $urandom);
                axes_left = $urandom_range(1, 10);
                for (int a = 0; a < axes_left; a++) begin
                    send_item(random_axis(), $urandom_range(0, 2) == 0);
                    count++;
                end
                if (phase == 2 && s == 3) hold_off = 1;
                for (int l = 0; l < 8; l++) begin
                    // back to back during the long receiver hold-off
                    send_item(random_locate(), hold_off || $urandom_range(0, 2) == 0);
                    count++;
                end
                if ($urandom_range(0, 9) == 0) begin
                    send_op(OP_NONE, 16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom), $urandom);
                end
            end
        end
        in_valid <= 0;
        stim_done = 1;

        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
